/* sv/tlpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpt_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int DIR_SHIFT  = 22;
  localparam int INDEX_W    = 10;
  localparam int FRAME_W    = 20;
  localparam int FLAG_W     = 3;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;

  // Flag bit positions
  localparam int F_PRESENT  = 0;
  localparam int F_WRITABLE = 1;
  localparam int F_USER     = 2;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_MAP       = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT    = 2'd2;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
  } tab_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   translated_address;
    logic [FRAME_W-1:0]  released_frame;
    logic                release_valid;
    logic                flush_request;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t result;
  } seq_ctl_t;

endpackage

/* sv/tlpt_if.sv */
// ----------------------------------------------------------------------------
// tlpt_if
// Request and response channels of the page table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] virtual_address;
  logic [31:0] physical_address;
  logic [2:0]  flags;

  modport source (output valid, operation, virtual_address, physical_address, flags,
                  input ready);
  modport sink   (input valid, operation, virtual_address, physical_address, flags,
                  output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] translated_address;
  logic [19:0] released_frame;
  logic        release_valid;
  logic        flush_request;

  modport source (output valid, status, translated_address, released_frame,
                  release_valid, flush_request, input ready);
  modport sink   (input valid, status, translated_address, released_frame,
                  release_valid, flush_request, output ready);
endinterface

/* sv/two_level_page_table_engine.sv */
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// Response path: the request is registered, the directory entry is read in S_DIR,
// the table entry is read in S_TAB (translate, unmap of a present directory entry),
// then S_RESP hands the result to the output register, waiting while it is full.
// One operation at a time: a new request is taken only after that handoff.
// Reset: a pass over TABLE_SLOTS*1024 entries zeroes both stores, request.ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_page_table_engine #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  tlpt_req_if.sink   request,
  tlpt_rsp_if.source response
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DIR_W  = tlpt_pkg::FLAG_W + SLOT_W;
  localparam int TAB_AW = $clog2(TABLE_SLOTS * 1024);
  localparam int TAB_W  = $bits(tlpt_pkg::tab_entry_t);

  tlpt_pkg::seq_ctl_t             ctl;
  logic                           out_free;
  logic                           clearing;
  logic                           dir_we;
  logic [tlpt_pkg::INDEX_W-1:0]   dir_wr_addr;
  logic [DIR_W-1:0]               dir_wr_data;
  logic [tlpt_pkg::INDEX_W-1:0]   dir_rd_addr;
  logic [DIR_W-1:0]               dir_rd_data;
  logic                           tab_we;
  logic [TAB_AW-1:0]              tab_wr_addr;
  logic [TAB_W-1:0]               tab_wr_data;
  logic [TAB_AW-1:0]              tab_rd_addr;
  logic [TAB_W-1:0]               tab_rd_data;

  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (1024)
  ) u_dir_ram (
    .clk     (clk),
    .we      (dir_we),
    .wr_addr (dir_wr_addr),
    .wr_data (dir_wr_data),
    .rd_addr (dir_rd_addr),
    .rd_data (dir_rd_data)
  );

  tlpt_ram #(
    .WIDTH (TAB_W),
    .DEPTH (TABLE_SLOTS * 1024)
  ) u_tab_ram (
    .clk     (clk),
    .we      (tab_we),
    .wr_addr (tab_wr_addr),
    .wr_data (tab_wr_data),
    .rd_addr (tab_rd_addr),
    .rd_data (tab_rd_data)
  );

  tlpt_seq #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .out_free    (out_free),
    .ctl         (ctl),
    .clearing    (clearing),
    .dir_we      (dir_we),
    .dir_wr_addr (dir_wr_addr),
    .dir_wr_data (dir_wr_data),
    .dir_rd_addr (dir_rd_addr),
    .dir_rd_data (dir_rd_data),
    .tab_we      (tab_we),
    .tab_wr_addr (tab_wr_addr),
    .tab_wr_data (tab_wr_data),
    .tab_rd_addr (tab_rd_addr),
    .tab_rd_data (tab_rd_data)
  );

  tlpt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .free     (out_free),
    .response (response)
  );

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !request.ready)
    else $error("request accepted during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("second request taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (!response.valid || response.ready))
    else $error("pending response overwritten");

  a_flush_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.flush_request) |->
      (response.status == tlpt_pkg::STATUS_DONE))
    else $error("flush requested on failed operation");
`endif

endmodule

/* sv/tlpt_ram.sv */
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/tlpt_seq.sv */
// ----------------------------------------------------------------------------
// tlpt_seq
// Sequencer: clears both stores after reset, then walks each operation through a
// directory read and, where the operation and directory entry call for it, a table read or write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpt_seq #(
  parameter int TABLE_SLOTS = 16,
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int NFS_W  = $clog2(TABLE_SLOTS + 1),
  localparam int DIR_W  = tlpt_pkg::FLAG_W + SLOT_W,
  localparam int TAB_AW = $clog2(TABLE_SLOTS * 1024),
  localparam int TAB_W  = $bits(tlpt_pkg::tab_entry_t)
) (
  input  logic                     clk,
  input  logic                     rst,
  tlpt_req_if.sink                 request,
  input  logic                     out_free,
  output tlpt_pkg::seq_ctl_t       ctl,
  output logic                     clearing,
  // directory store
  output logic                     dir_we,
  output logic [tlpt_pkg::INDEX_W-1:0] dir_wr_addr,
  output logic [DIR_W-1:0]         dir_wr_data,
  output logic [tlpt_pkg::INDEX_W-1:0] dir_rd_addr,
  input  logic [DIR_W-1:0]         dir_rd_data,
  // table store
  output logic                     tab_we,
  output logic [TAB_AW-1:0]        tab_wr_addr,
  output logic [TAB_W-1:0]         tab_wr_data,
  output logic [TAB_AW-1:0]        tab_rd_addr,
  input  logic [TAB_W-1:0]         tab_rd_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TAB,
    S_RESP
  } state_t;

  state_t                            state;
  logic [TAB_AW-1:0]                 clr_cnt;
  logic [NFS_W-1:0]                  next_free_slot;
  tlpt_pkg::op_t                     op;
  logic [tlpt_pkg::ADDR_W-1:0]       va;
  logic [tlpt_pkg::FRAME_W-1:0]      pa_frame;
  logic [tlpt_pkg::FLAG_W-1:0]       fl;
  logic [TAB_AW-1:0]                 tab_addr;
  tlpt_pkg::result_t                 res;

  logic                              dir_present;
  logic [SLOT_W-1:0]                 dir_slot;
  logic                              have_space;
  logic [SLOT_W-1:0]                 map_slot;
  logic [TAB_AW-1:0]                 tab_index;
  logic                              map_alloc;
  logic                              map_write;
  tlpt_pkg::tab_entry_t              entry;

  assign dir_present = dir_rd_data[tlpt_pkg::F_PRESENT];
  assign dir_slot    = dir_rd_data[DIR_W-1:tlpt_pkg::FLAG_W];
  assign have_space  = next_free_slot < NFS_W'(TABLE_SLOTS);
  assign map_slot    = dir_present ? dir_slot : next_free_slot[SLOT_W-1:0];
  assign tab_index   = TAB_AW'({map_slot,
                                va[tlpt_pkg::PAGE_SHIFT +: tlpt_pkg::INDEX_W]});
  assign map_alloc   = (state == S_DIR) && (op == tlpt_pkg::OP_MAP) && !dir_present
                       && have_space;
  assign map_write   = (state == S_DIR) && (op == tlpt_pkg::OP_MAP)
                       && (dir_present || have_space);
  assign entry       = tlpt_pkg::tab_entry_t'(tab_rd_data);

  assign request.ready = (state == S_IDLE);
  assign clearing      = (state == S_CLEAR);
  assign ctl.load      = (state == S_RESP) && out_free;
  assign ctl.result    = res;

  // Directory is read at the incoming address so the entry is ready in the cycle
  // after the transfer.
  assign dir_rd_addr = request.virtual_address[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::INDEX_W];
  assign tab_rd_addr = tab_index;

  always_comb begin
    dir_we      = 1'b0;
    dir_wr_addr = va[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::INDEX_W];
    dir_wr_data = {next_free_slot[SLOT_W-1:0], fl[tlpt_pkg::F_USER], 1'b1, 1'b1};
    tab_we      = 1'b0;
    tab_wr_addr = tab_index;
    tab_wr_data = {pa_frame, fl};
    if (state == S_CLEAR) begin
      dir_we      = 1'b1;
      dir_wr_addr = clr_cnt[tlpt_pkg::INDEX_W-1:0];
      dir_wr_data = '0;
      tab_we      = 1'b1;
      tab_wr_addr = clr_cnt;
      tab_wr_data = '0;
    end else if (map_alloc || map_write) begin
      dir_we = map_alloc;
      tab_we = map_write;
    end else if ((state == S_TAB) && (op == tlpt_pkg::OP_UNMAP)) begin
      tab_we      = 1'b1;
      tab_wr_addr = tab_addr;
      tab_wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      next_free_slot <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + TAB_AW'(1);
          if (clr_cnt == TAB_AW'(TABLE_SLOTS * 1024 - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (request.valid) begin
            op       <= tlpt_pkg::op_t'(request.operation);
            va       <= request.virtual_address;
            pa_frame <= request.physical_address[tlpt_pkg::PAGE_SHIFT +: tlpt_pkg::FRAME_W];
            fl       <= request.flags;
            res      <= '0;
            state    <= S_DIR;
          end
        end
        S_DIR: begin
          tab_addr <= tab_index;
          state    <= S_RESP;
          case (op)
            tlpt_pkg::OP_TRANSLATE, tlpt_pkg::OP_UNMAP: begin
              if (!dir_present) begin
                res.status <= tlpt_pkg::STATUS_NOT_MAPPED;
              end else begin
                state <= S_TAB;
              end
            end
            tlpt_pkg::OP_MAP: begin
              if (map_write) begin
                res.flush_request <= 1'b1;
              end else begin
                res.status <= tlpt_pkg::STATUS_NO_SLOT;
              end
              if (map_alloc) begin
                next_free_slot <= next_free_slot + NFS_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_TAB: begin
          state <= S_RESP;
          if (op == tlpt_pkg::OP_UNMAP) begin
            res.released_frame <= entry.frame;
            res.release_valid  <= (entry.frame != '0);
            res.flush_request  <= 1'b1;
          end else if (entry.flags[tlpt_pkg::F_PRESENT]) begin
            res.translated_address <= {entry.frame, va[tlpt_pkg::PAGE_SHIFT-1:0]};
          end else begin
            res.status <= tlpt_pkg::STATUS_NOT_MAPPED;
          end
        end
        S_RESP: begin
          // hold until the output register can take the result
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/tlpt_out_reg.sv */
// ----------------------------------------------------------------------------
// tlpt_out_reg
// Output register of the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpt_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  tlpt_pkg::seq_ctl_t ctl,
  output logic               free,
  tlpt_rsp_if.source         response
);

  logic              valid;
  tlpt_pkg::result_t res;

  assign free = !valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (response.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res <= ctl.result;
    end
  end

  assign response.valid              = valid;
  assign response.status             = res.status;
  assign response.translated_address = res.translated_address;
  assign response.released_frame     = res.released_frame;
  assign response.release_valid      = res.release_valid;
  assign response.flush_request      = res.flush_request;

endmodule

/* tb/sv/two_level_page_table_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_checker
// Watches the request and response channels of the page table engine. Keeps
// its own copy of the directory, the page table pool and the slot counter,
// works out the response of every accepted request and compares each
// accepted response, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------

module two_level_page_table_engine_checker #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  tlpt_req_if         request,
  tlpt_rsp_if         response,
  output int unsigned fail_count,
  output int unsigned open_walks,
  output int unsigned responses_checked,
  output int unsigned translate_hits,
  output int unsigned slot_refusals,
  output int unsigned frames_released
);

  typedef struct packed {
    logic       present;
    logic       writable;
    logic       user;
    logic [9:0] slot;
  } dir_entry_t;

  typedef struct {
    tlpt_pkg::op_t     op;
    tlpt_pkg::result_t res;
  } walk_t;

  dir_entry_t           directory [1024];
  tlpt_pkg::tab_entry_t page_entries [TABLE_SLOTS*1024];
  int unsigned          tables_claimed;
  walk_t                expected_walks [$];
  walk_t                accepted_walk;
  int unsigned          response_no;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one operation to the shadow tables and return its response.
  function automatic tlpt_pkg::result_t apply_page_op(input tlpt_pkg::op_t op,
                                                      input logic [31:0] va,
                                                      input logic [31:0] pa,
                                                      input logic [2:0] fl);
    tlpt_pkg::result_t res;
    logic [9:0]        dir_ix;
    logic [9:0]        tab_ix;
    int unsigned       entry_ix;
    dir_ix = va[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::INDEX_W];
    tab_ix = va[tlpt_pkg::PAGE_SHIFT +: tlpt_pkg::INDEX_W];
    res = '0;
    if (op == tlpt_pkg::OP_MAP && !directory[dir_ix].present) begin
      if (tables_claimed >= TABLE_SLOTS) begin
        res.status = tlpt_pkg::STATUS_NO_SLOT;
      end else begin
        directory[dir_ix] = '{present: 1'b1, writable: 1'b1, user: fl[tlpt_pkg::F_USER],
                              slot: 10'(tables_claimed)};
        tables_claimed++;
      end
    end
    entry_ix = int'(directory[dir_ix].slot) * 1024 + int'(tab_ix);
    case (op)
      tlpt_pkg::OP_TRANSLATE: begin
        if (directory[dir_ix].present && page_entries[entry_ix].flags[tlpt_pkg::F_PRESENT])
          res.translated_address = {page_entries[entry_ix].frame,
                                    va[tlpt_pkg::PAGE_SHIFT-1:0]};
        else
          res.status = tlpt_pkg::STATUS_NOT_MAPPED;
      end
      tlpt_pkg::OP_MAP: begin
        if (res.status != tlpt_pkg::STATUS_NO_SLOT) begin
          page_entries[entry_ix] = '{frame: pa[tlpt_pkg::ADDR_W-1:tlpt_pkg::PAGE_SHIFT],
                                     flags: fl};
          res.flush_request = 1'b1;
        end
      end
      tlpt_pkg::OP_UNMAP: begin
        if (!directory[dir_ix].present) begin
          res.status = tlpt_pkg::STATUS_NOT_MAPPED;
        end else begin
          // the frame goes back even when the entry was not present
          res.released_frame = page_entries[entry_ix].frame;
          res.release_valid  = |page_entries[entry_ix].frame;
          page_entries[entry_ix] = '0;
          res.flush_request = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_response();
    walk_t             want;
    tlpt_pkg::result_t got;
    got.status             = response.status;
    got.translated_address = response.translated_address;
    got.released_frame     = response.released_frame;
    got.release_valid      = response.release_valid;
    got.flush_request      = response.flush_request;
    response_no++;
    if (expected_walks.size() == 0) begin
      report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                response_no));
      return;
    end
    want = expected_walks.pop_front();
    responses_checked++;
    if (got.status !== want.res.status)
      report_mismatch($sformatf("response %0d (%s) status 0x%0h, expected 0x%0h",
                                response_no, want.op.name(), got.status, want.res.status));
    if (got.translated_address !== want.res.translated_address)
      report_mismatch($sformatf("response %0d (%s) translated_address 0x%0h, expected 0x%0h",
                                response_no, want.op.name(), got.translated_address,
                                want.res.translated_address));
    if (got.released_frame !== want.res.released_frame)
      report_mismatch($sformatf("response %0d (%s) released_frame 0x%0h, expected 0x%0h",
                                response_no, want.op.name(), got.released_frame,
                                want.res.released_frame));
    if (got.release_valid !== want.res.release_valid)
      report_mismatch($sformatf("response %0d (%s) release_valid %b, expected %b",
                                response_no, want.op.name(), got.release_valid,
                                want.res.release_valid));
    if (got.flush_request !== want.res.flush_request)
      report_mismatch($sformatf("response %0d (%s) flush_request %b, expected %b",
                                response_no, want.op.name(), got.flush_request,
                                want.res.flush_request));
    if (want.op == tlpt_pkg::OP_TRANSLATE && want.res.status == tlpt_pkg::STATUS_DONE)
      translate_hits++;
    if (want.res.status == tlpt_pkg::STATUS_NO_SLOT) slot_refusals++;
    if (want.res.release_valid) frames_released++;
  endtask

  initial begin
    fail_count        = 0;
    responses_checked = 0;
    translate_hits    = 0;
    slot_refusals     = 0;
    frames_released   = 0;
    response_no       = 0;
    open_walks        = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (directory[i]) directory[i] = '0;
      foreach (page_entries[i]) page_entries[i] = '0;
      tables_claimed = 0;
      expected_walks.delete();
    end else begin
      // check before predicting so a new request never pairs with a response
      if (response.valid && response.ready) check_response();
      if (request.valid && request.ready) begin
        accepted_walk.op  = tlpt_pkg::op_t'(request.operation);
        accepted_walk.res = apply_page_op(tlpt_pkg::op_t'(request.operation),
                                          request.virtual_address,
                                          request.physical_address, request.flags);
        expected_walks.push_back(accepted_walk);
      end
    end
    open_walks <= expected_walks.size();
  end

endmodule

/* tb/sv/two_level_page_table_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_tb
// Drives map, unmap, translate and idle operations into the page table
// engine: a directed opening, then random traffic concentrated on a few
// directory and table indexes so that pages are hit, remapped and freed and
// the table pool runs out. Both channels idle at random; one phase holds
// responses off for a long stretch. The checker beside the block scores it.
// ----------------------------------------------------------------------------

module two_level_page_table_engine_tb;

  localparam int TABLE_SLOTS   = 16;
  localparam int HALF_PERIOD   = 6;
  localparam int LONG_HOLD     = 200;
  localparam int DRAIN_TAIL    = 10;
  localparam int HOT_DIRS      = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit          quiet = 1'b0;
  bit          hold_responses = 1'b0;
  int unsigned sent_by_op [4];

  int unsigned fail_count;
  int unsigned open_walks;
  int unsigned responses_checked;
  int unsigned translate_hits;
  int unsigned slot_refusals;
  int unsigned frames_released;

  tlpt_req_if request();
  tlpt_rsp_if response();

  two_level_page_table_engine #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  two_level_page_table_engine_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) walk_check (
    .clk               (clk),
    .rst               (rst),
    .request           (request),
    .response          (response),
    .fail_count        (fail_count),
    .open_walks        (open_walks),
    .responses_checked (responses_checked),
    .translate_hits    (translate_hits),
    .slot_refusals     (slot_refusals),
    .frames_released   (frames_released)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Mostly no gap, some short, a few long.
  function automatic int idle_length();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Offer one request after an optional gap and hold it until the transfer.
  task automatic send_request(input tlpt_pkg::op_t op, input logic [31:0] va,
                              input logic [31:0] pa, input logic [2:0] fl,
                              input int gap);
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid            <= 1'b1;
    request.operation        <= op;
    request.virtual_address  <= va;
    request.physical_address <= pa;
    request.flags            <= fl;
    sent_by_op[op]++;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  task automatic send_random(input int gap);
    tlpt_pkg::op_t op;
    logic [31:0]   va;
    logic [31:0]   pa;
    logic [2:0]    fl;
    logic [9:0]    dir_ix;
    logic [9:0]    tab_ix;
    int unsigned   r;
    int unsigned   k;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      op = tlpt_pkg::op_t'(2'($urandom_range(0, 3)));
      va = $urandom;
      pa = $urandom;
      fl = 3'($urandom_range(0, 7));
    end else begin
      r = $urandom_range(0, 99);
      op = (r < 42) ? tlpt_pkg::OP_TRANSLATE :
           (r < 77) ? tlpt_pkg::OP_MAP :
           (r < 97) ? tlpt_pkg::OP_UNMAP : tlpt_pkg::OP_NOP;
      // more directory indexes than table slots, so the pool runs dry
      k = $urandom_range(0, HOT_DIRS - 1);
      dir_ix = (k == HOT_DIRS - 1) ? 10'h3FF : 10'(k * 41);
      tab_ix = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 7))
                                            : 10'($urandom_range(0, 1023));
      va = {dir_ix, tab_ix, 12'($urandom_range(0, 4095))};
      pa = $urandom;
      fl = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 8) fl[tlpt_pkg::F_PRESENT] = 1'b1;
    end
    send_request(op, va, pa, fl, gap);
  endtask

  // Drop valid and wait until every outstanding response has come back.
  task automatic drain_responses();
    request.valid <= 1'b0;
    @(posedge clk);
    while (open_walks != 0) @(posedge clk);
  endtask

  initial begin : response_pacing
    int stall;
    response.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_responses) begin
        response.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_responses = 1'b0;
      end else begin
        stall = idle_length();
        if (stall > 0) begin
          response.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      response.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    request.valid            <= 1'b0;
    request.operation        <= tlpt_pkg::OP_NOP;
    request.virtual_address  <= '0;
    request.physical_address <= '0;
    request.flags            <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty tables, then the top and bottom of the address space.
    send_request(tlpt_pkg::OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_UNMAP,     32'h0000_0000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_MAP,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, idle_length());
    send_request(tlpt_pkg::OP_TRANSLATE, 32'hFFFF_F123, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_MAP,       32'h0000_0ABC, 32'h1234_5FFF, 3'b011, idle_length());
    send_request(tlpt_pkg::OP_TRANSLATE, 32'h0000_0FFF, 32'hFFFF_FFFF, 3'b111, idle_length());
    // directory present, page absent
    send_request(tlpt_pkg::OP_TRANSLATE, 32'h0000_1000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_UNMAP,     32'h0000_1000, 32'h0000_0000, 3'b000, idle_length());
    // mapped with present clear: written, not translatable, frame still released
    send_request(tlpt_pkg::OP_MAP,       32'h0000_2000, 32'hABCD_E000, 3'b110, idle_length());
    send_request(tlpt_pkg::OP_TRANSLATE, 32'h0000_2345, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_UNMAP,     32'h0000_2000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_UNMAP,     32'hFFFF_F000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000, 3'b000, idle_length());
    // frame zero: flush without a release
    send_request(tlpt_pkg::OP_MAP,       32'h0000_3000, 32'h0000_0FFF, 3'b001, idle_length());
    send_request(tlpt_pkg::OP_UNMAP,     32'h0000_3000, 32'h0000_0000, 3'b000, idle_length());
    send_request(tlpt_pkg::OP_NOP,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, idle_length());
    send_request(tlpt_pkg::OP_MAP,       32'h0040_0000, 32'h8000_0000, 3'b100, idle_length());
    send_request(tlpt_pkg::OP_MAP,       32'h0000_0000, 32'h5555_5000, 3'b101, idle_length());
    send_request(tlpt_pkg::OP_TRANSLATE, 32'h0000_0AAA, 32'h0000_0000, 3'b000, idle_length());
    drain_responses();

    repeat (200) send_random(idle_length());

    // Stall responses while requests keep coming.
    hold_responses = 1'b1;
    repeat (10) send_random(0);
    drain_responses();

    quiet = 1'b1;
    repeat (150) send_random(0);
    quiet = 1'b0;

    repeat (290) send_random(idle_length());

    drain_responses();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("run covered %0d requests: %0d translate, %0d map, %0d unmap, %0d idle op",
             sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3],
             sent_by_op[tlpt_pkg::OP_TRANSLATE], sent_by_op[tlpt_pkg::OP_MAP],
             sent_by_op[tlpt_pkg::OP_UNMAP], sent_by_op[tlpt_pkg::OP_NOP]);
    $display("%0d responses compared, %0d translation hits, %0d maps out of tables, %s",
             responses_checked, translate_hits, slot_refusals,
             $sformatf("%0d frames freed", frames_released));
    if (fail_count == 0 && open_walks == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
